>>> hdl/mrf_pkg.sv
package mrf_pkg;

  localparam int CmdW  = 3;
  localparam int WordW = 32;
  localparam int ByteW = 8;
  localparam int CrcW  = 16;
  localparam int IdxW  = 5;

  localparam logic [CrcW-1:0]  CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPoly = 16'hA001;
  localparam logic [ByteW-1:0] AddrRst = 8'h01;

  localparam logic [ByteW-1:0] FnReadHold  = 8'h03;
  localparam logic [ByteW-1:0] FnWriteMult = 8'h10;
  localparam logic [ByteW-1:0] RegVoltage  = 8'h07;
  localparam logic [ByteW-1:0] RegCurrent  = 8'h09;
  localparam logic [ByteW-1:0] RegStop     = 8'h0B;
  localparam logic [ByteW-1:0] QtyPoll     = 8'h07;
  localparam logic [ByteW-1:0] QtyBoth     = 8'h05;
  localparam logic [ByteW-1:0] QtyWord     = 8'h02;
  localparam logic [ByteW-1:0] QtyStop     = 8'h01;
  localparam logic [ByteW-1:0] CntBoth     = 8'h0A;
  localparam logic [ByteW-1:0] CntWord     = 8'h04;
  localparam logic [ByteW-1:0] CntStop     = 8'h02;
  localparam logic [ByteW-1:0] OutOn       = 8'hFF;
  localparam logic [ByteW-1:0] ByteZero    = 8'h00;

  localparam logic [IdxW-1:0] LenPoll = 5'd6;
  localparam logic [IdxW-1:0] LenBoth = 5'd17;
  localparam logic [IdxW-1:0] LenWord = 5'd11;
  localparam logic [IdxW-1:0] LenStop = 5'd9;

  typedef enum logic [CmdW-1:0] {
    CMD_POLL     = 3'd0,
    CMD_SET_BOTH = 3'd1,
    CMD_SET_VOLT = 3'd2,
    CMD_SET_CURR = 3'd3,
    CMD_STOP     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    PH_BODY,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [ByteW-1:0] addr;
    logic [WordW-1:0] vol;
    logic [WordW-1:0] cur;
    logic             oe;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [IdxW-1:0] frame_len_f(input cmd_t cmd);
    logic [IdxW-1:0] len;
    case (cmd)
      CMD_POLL:     len = LenPoll;
      CMD_SET_BOTH: len = LenBoth;
      CMD_SET_VOLT: len = LenWord;
      CMD_SET_CURR: len = LenWord;
      CMD_STOP:     len = LenStop;
      default:      len = LenPoll;
    endcase
    return len;
  endfunction

  function automatic logic [ByteW-1:0] word_byte_f(input logic [WordW-1:0] w,
                                                   input logic [1:0] sel);
    logic [ByteW-1:0] b;
    case (sel)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [ByteW-1:0] frame_byte_f(input desc_t d,
                                                    input logic [IdxW-1:0] idx);
    logic [ByteW-1:0] fn;
    logic [ByteW-1:0] reg_lo;
    logic [ByteW-1:0] qty;
    logic [ByteW-1:0] cnt;
    logic [WordW-1:0] w;
    logic [IdxW-1:0]  off;
    logic [ByteW-1:0] b;
    fn     = FnWriteMult;
    reg_lo = RegVoltage;
    qty    = QtyWord;
    cnt    = CntWord;
    w      = d.vol;
    case (d.cmd)
      CMD_POLL: begin
        fn     = FnReadHold;
        reg_lo = ByteZero;
        qty    = QtyPoll;
      end
      CMD_SET_BOTH: begin
        qty = QtyBoth;
        cnt = CntBoth;
      end
      CMD_SET_VOLT: begin
        w = d.vol;
      end
      CMD_SET_CURR: begin
        reg_lo = RegCurrent;
        w      = d.cur;
      end
      CMD_STOP: begin
        reg_lo = RegStop;
        qty    = QtyStop;
        cnt    = CntStop;
      end
      default: begin
        fn = FnWriteMult;
      end
    endcase
    off = idx - 5'd7;
    case (idx)
      5'd0:    b = d.addr;
      5'd1:    b = fn;
      5'd2:    b = ByteZero;
      5'd3:    b = reg_lo;
      5'd4:    b = ByteZero;
      5'd5:    b = qty;
      5'd6:    b = cnt;
      5'd7, 5'd8, 5'd9, 5'd10: begin
        b = (d.cmd == CMD_STOP) ? ByteZero : word_byte_f(w, off[1:0]);
      end
      5'd11, 5'd12, 5'd13, 5'd14: b = word_byte_f(d.cur, off[1:0]);
      5'd15:   b = d.oe ? OutOn : ByteZero;
      default: b = ByteZero;
    endcase
    return b;
  endfunction

  function automatic logic [CrcW-1:0] crc_step_f(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < ByteW; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/mrf_ifs.sv
interface mrf_in_if import mrf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [WordW-1:0] voltage_milli;
  logic [WordW-1:0] current_milli;
  logic             output_enable;
  modport source(output valid, command, voltage_milli, current_milli, output_enable,
                 input ready);
  modport sink(input valid, command, voltage_milli, current_milli, output_enable,
               output ready);
endinterface

interface mrf_out_if import mrf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] frame_byte;
  logic             last_byte;
  modport source(output valid, frame_byte, last_byte, input ready);
  modport sink(input valid, frame_byte, last_byte, output ready);
endinterface

interface mrf_cfg_if import mrf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

>>> hdl/mrf_front.sv
module mrf_front import mrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mrf_in_if.sink      in_ch,
  mrf_cfg_if.sink     cfg_ch,
  input  q_stat_t     q_stat,
  output logic        push,
  output desc_t       push_desc
);

  logic [ByteW-1:0] addr_r;
  logic [ByteW-1:0] addr_nxt;
  logic             cmd_ok;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_stat.full;

  always_comb begin
    addr_nxt = addr_r;
    if (cfg_ch.valid) begin
      addr_nxt = cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= AddrRst;
    end else begin
      addr_r <= addr_nxt;
    end
  end

  // drop unused command codes
  assign cmd_ok = in_ch.command inside {[CMD_POLL:CMD_STOP]};
  assign push   = in_ch.valid && in_ch.ready && cmd_ok;

  always_comb begin
    push_desc.cmd  = cmd_t'(in_ch.command);
    push_desc.addr = addr_r;
    push_desc.vol  = in_ch.voltage_milli;
    push_desc.cur  = in_ch.current_milli;
    push_desc.oe   = in_ch.output_enable;
  end

endmodule

>>> hdl/mrf_queue.sv
module mrf_queue import mrf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  desc_t   push_desc,
  input  logic    pop,
  output q_stat_t q_stat,
  output desc_t   head
);

  desc_t      slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign q_stat.full  = count_r == 2'd2;
  assign q_stat.empty = count_r == 2'd0;
  assign head         = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

>>> hdl/mrf_back.sv
module mrf_back import mrf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  q_stat_t  q_stat,
  input  desc_t    head,
  output logic     pop,
  mrf_out_if.source out_ch
);

  phase_t           state_r;
  phase_t           state_nxt;
  logic [IdxW-1:0]  idx_r;
  logic [IdxW-1:0]  idx_nxt;
  logic [CrcW-1:0]  crc_r;
  logic [CrcW-1:0]  crc_nxt;
  logic             ov_r;
  logic             ov_nxt;
  logic [ByteW-1:0] ob_r;
  logic             ol_r;
  logic             adv;
  logic             body_end;
  logic [ByteW-1:0] byte_sel;
  logic             last_sel;

  assign adv      = !q_stat.empty && (!ov_r || out_ch.ready);
  assign body_end = idx_r == frame_len_f(head.cmd) - 5'd1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PH_BODY: begin
        if (adv && body_end) begin
          state_nxt = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        if (adv) begin
          state_nxt = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        if (adv) begin
          state_nxt = PH_BODY;
        end
      end
      default: state_nxt = PH_BODY;
    endcase
  end

  always_comb begin
    byte_sel = frame_byte_f(head, idx_r);
    last_sel = 1'b0;
    pop      = 1'b0;
    idx_nxt  = idx_r;
    crc_nxt  = crc_r;
    case (state_r)
      PH_BODY: begin
        if (adv) begin
          idx_nxt = idx_r + 5'd1;
          crc_nxt = crc_step_f(crc_r, byte_sel);
        end
      end
      PH_CRC_LO: begin
        byte_sel = crc_r[7:0];
      end
      PH_CRC_HI: begin
        byte_sel = crc_r[15:8];
        last_sel = 1'b1;
        pop      = adv;
        if (adv) begin
          idx_nxt = '0;
          crc_nxt = CrcInit;
        end
      end
      default: begin
        byte_sel = ByteZero;
      end
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (adv) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_BODY;
      idx_r   <= '0;
      crc_r   <= CrcInit;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // hold the beat while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      ob_r <= byte_sel;
      ol_r <= last_sel;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.frame_byte = ob_r;
  assign out_ch.last_byte  = ol_r;

endmodule

>>> hdl/modbus_request_framer_core.sv
// Modbus RTU request framer.
// in_ch takes one command beat (command, voltage_milli, current_milli,
// output_enable); each valid command yields one request frame on out_ch as
// a run of byte beats, last_byte set on the trailing CRC high byte.
// Command codes 5 to 7 are accepted and dropped without output.
// cfg_ch writes the slave address (reset value 1); it is always ready and
// the address is sampled when a command is accepted.
// An accepted command is written into the queue; when the back end is free,
// its first byte is then registered into the out_ch beat and shown valid.
// Throughput: one byte per cycle from the serializer while out_ch is ready;
// a frame has 8 (poll), 11 (stop), 13 (set voltage or set current) or
// 19 (set both) bytes. The frame being sent keeps its command in the
// two-entry queue, so one further command is accepted while it is sent.
// Reset (rst_n low, synchronous) empties the queue, drops any frame in
// flight and restores the slave address.
// When out_ch stalls, the pending byte holds; the serializer stops, and
// in_ch deasserts ready once the queue is full.
module modbus_request_framer_core import mrf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mrf_in_if.sink     in_ch,
  mrf_cfg_if.sink    cfg_ch,
  mrf_out_if.source  out_ch
);

  q_stat_t q_stat;
  logic    push;
  desc_t   push_desc;
  logic    pop;
  desc_t   head;

  mrf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_desc (push_desc)
  );

  mrf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .q_stat    (q_stat),
    .head      (head)
  );

  mrf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

>>> hdl/mrf_checker.sv
module mrf_checker import mrf_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ByteW-1:0] out_byte,
  input logic             out_last
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled beat changed");

  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked with no output pending");

endmodule

bind modbus_request_framer_core mrf_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.frame_byte),
  .out_last  (out_ch.last_byte)
);

>>> dv/mrf_frame_checker.sv
`timescale 1ns / 100ps

module mrf_frame_checker import mrf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mrf_in_if    in_ch,
  mrf_cfg_if   cfg_ch,
  mrf_out_if   out_ch,
  output int   fail_count,
  output int   beats_pending
);

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } frame_beat_t;

  frame_beat_t      expected_beats[$];
  frame_beat_t      head_beat;
  logic [ByteW-1:0] station_addr;

  function automatic logic [CrcW-1:0] modbus_crc_byte(input logic [CrcW-1:0] crc,
                                                      input logic [ByteW-1:0] b);
    logic [CrcW-1:0] acc;
    acc = crc ^ {8'h00, b};
    for (int k = 0; k < ByteW; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  task automatic push_request_frame(input logic [CmdW-1:0]  code,
                                    input logic [WordW-1:0] volt,
                                    input logic [WordW-1:0] amps,
                                    input logic             oe_bit);
    logic [ByteW-1:0] body[$];
    logic [CrcW-1:0]  crc;
    frame_beat_t      beat;
    case (code)
      CMD_POLL: begin
        body = {station_addr, FnReadHold, ByteZero, ByteZero, ByteZero, QtyPoll};
      end
      CMD_SET_BOTH: begin
        body = {station_addr, FnWriteMult, ByteZero, RegVoltage, ByteZero, QtyBoth,
                CntBoth, volt[31:24], volt[23:16], volt[15:8], volt[7:0],
                amps[31:24], amps[23:16], amps[15:8], amps[7:0],
                oe_bit ? OutOn : ByteZero, ByteZero};
      end
      CMD_SET_VOLT: begin
        body = {station_addr, FnWriteMult, ByteZero, RegVoltage, ByteZero, QtyWord,
                CntWord, volt[31:24], volt[23:16], volt[15:8], volt[7:0]};
      end
      CMD_SET_CURR: begin
        body = {station_addr, FnWriteMult, ByteZero, RegCurrent, ByteZero, QtyWord,
                CntWord, amps[31:24], amps[23:16], amps[15:8], amps[7:0]};
      end
      CMD_STOP: begin
        body = {station_addr, FnWriteMult, ByteZero, RegStop, ByteZero, QtyStop,
                CntStop, ByteZero, ByteZero};
      end
      default: begin
        return;
      end
    endcase
    crc = CrcInit;
    foreach (body[i]) crc = modbus_crc_byte(crc, body[i]);
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    foreach (body[i]) begin
      beat.data = body[i];
      beat.last = (i == body.size() - 1);
      expected_beats.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      station_addr = AddrRst;
      expected_beats.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        station_addr = cfg_ch.data;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          fail_count++;
          $error("frame_byte: expected no beat, got %02h", out_ch.frame_byte);
        end else begin
          head_beat = expected_beats.pop_front();
          if (out_ch.frame_byte !== head_beat.data) begin
            fail_count++;
            $error("frame_byte: expected %02h, got %02h", head_beat.data,
                   out_ch.frame_byte);
          end
          if (out_ch.last_byte !== head_beat.last) begin
            fail_count++;
            $error("last_byte: expected %0b, got %0b", head_beat.last,
                   out_ch.last_byte);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        push_request_frame(in_ch.command, in_ch.voltage_milli, in_ch.current_milli,
                           in_ch.output_enable);
      end
    end
    beats_pending = expected_beats.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mrf_pkg::*;

  localparam logic [CmdW-1:0] CmdUnusedLo = 3'd5;
  localparam logic [CmdW-1:0] CmdUnusedHi = 3'd7;
  localparam int DrainCycles = 30;
  localparam int HoldCycles  = 300;
  localparam int WatchLimit  = 3000;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   beats_pending;
  int   send_gap_max  = 10;
  int   sink_stall_max = 10;
  int   sink_hold     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mrf_in_if  in_ch();
  mrf_cfg_if cfg_ch();
  mrf_out_if out_ch();

  modbus_request_framer_core i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg_ch(cfg_ch),
    .out_ch(out_ch)
  );

  mrf_frame_checker i_frame_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .cfg_ch       (cfg_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .beats_pending(beats_pending)
  );

  function automatic logic [WordW-1:0] random_word();
    logic [WordW-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic logic [CmdW-1:0] random_command();
    logic [CmdW-1:0] c;
    int              r;
    r = $urandom_range(0, 15);
    if (r < 14) begin
      c = CmdW'(r % 5);
    end else begin
      c = CmdW'($urandom_range(CmdUnusedLo, CmdUnusedHi));
    end
    return c;
  endfunction

  task automatic offer_command(input logic [CmdW-1:0]  c,
                               input logic [WordW-1:0] volt,
                               input logic [WordW-1:0] amps,
                               input logic             oe_bit);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= c;
    in_ch.voltage_milli <= volt;
    in_ch.current_milli <= amps;
    in_ch.output_enable <= oe_bit;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (beats_pending != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_station_addr(input logic [ByteW-1:0] addr);
    settle_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= addr;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    repeat (count) begin
      offer_command(random_command(), random_word(), random_word(), 1'($urandom));
    end
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = $urandom_range(0, sink_stall_max);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= WatchLimit) begin
        $display("modbus_request_framer_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_POLL;
    in_ch.voltage_milli <= '0;
    in_ch.current_milli <= '0;
    in_ch.output_enable <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.data         <= '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer_command(CMD_POLL, '0, '0, 1'b0);
    offer_command(CMD_POLL, '1, '1, 1'b1);
    offer_command(CMD_SET_BOTH, '0, '0, 1'b0);
    offer_command(CMD_SET_BOTH, '1, '1, 1'b1);
    offer_command(CMD_SET_BOTH, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    offer_command(CMD_SET_BOTH, 32'h8000_0001, 32'h0000_0001, 1'b0);
    offer_command(CMD_SET_VOLT, '0, '1, 1'b1);
    offer_command(CMD_SET_VOLT, '1, '0, 1'b0);
    offer_command(CMD_SET_VOLT, 32'hA5A5_5A5A, $urandom, 1'b0);
    offer_command(CMD_SET_CURR, '1, '0, 1'b1);
    offer_command(CMD_SET_CURR, '0, '1, 1'b0);
    offer_command(CMD_SET_CURR, $urandom, 32'h5A5A_A5A5, 1'b1);
    offer_command(CMD_STOP, '0, '0, 1'b0);
    offer_command(CMD_STOP, '1, '1, 1'b1);
    for (int c = CmdUnusedLo; c <= CmdUnusedHi; c++) begin
      offer_command(CmdW'(c), random_word(), random_word(), 1'($urandom));
    end
    offer_command(CMD_POLL, $urandom, $urandom, 1'b1);

    write_station_addr(8'h00);
    run_random(100);

    write_station_addr(8'hFF);
    send_gap_max   = 0;
    sink_stall_max = 0;
    run_random(100);
    send_gap_max   = 10;
    sink_stall_max = 10;

    // hold the sink off while the source keeps pushing, then pause until drained
    sink_hold    = HoldCycles;
    send_gap_max = 0;
    run_random(40);
    settle_idle();
    send_gap_max = 10;

    write_station_addr(ByteW'($urandom));
    run_random(115);

    write_station_addr(ByteW'($urandom));
    run_random(115);

    settle_idle();
    if (fail_count == 0 && beats_pending == 0) begin
      $display("modbus_request_framer_core: match");
    end else begin
      $display("modbus_request_framer_core: mismatch");
    end
    $finish;
  end

endmodule
